FILE: hdl/tea_pkg.sv
// Shared types and constants for the TEA block cipher unit.
package tea_pkg;

	// Rounds at the default configuration
	localparam int unsigned ROUNDS_DEFAULT = 32;

	// Golden-ratio round constant
	localparam logic [31:0] DELTA = 32'h9e37_79b9;

	// Width of the configuration register index
	localparam int unsigned CFG_INDEX_W = 2;

	// Configuration register indexes
	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_KEY_0 = 2'd0,
		CFG_KEY_1 = 2'd1,
		CFG_KEY_2 = 2'd2,
		CFG_KEY_3 = 2'd3
	} cfg_index_t;

	// Key word reset values
	localparam logic [31:0] KEY_0_RESET = 32'd1;
	localparam logic [31:0] KEY_1_RESET = 32'd2;
	localparam logic [31:0] KEY_2_RESET = 32'd3;
	localparam logic [31:0] KEY_3_RESET = 32'd4;

	// Operation codes
	localparam logic OP_ENCRYPT = 1'b0;
	localparam logic OP_DECRYPT = 1'b1;

	// Input beat
	typedef struct packed {
		logic        operation;
		logic [31:0] left_word;
		logic [31:0] right_word;
	} in_beat_t;

	// Output beat
	typedef struct packed {
		logic [31:0] out_left_word;
		logic [31:0] out_right_word;
	} out_beat_t;

	// Key words as seen by every stage
	typedef struct packed {
		logic [31:0] k0;
		logic [31:0] k1;
		logic [31:0] k2;
		logic [31:0] k3;
	} key_t;

	// Payload carried between pipeline stages
	typedef struct packed {
		logic        op;
		logic [31:0] y;
		logic [31:0] z;
	} stage_t;

	// Round sum: delta times a count, modulo 2^32
	function automatic logic [31:0] round_sum(input int unsigned count);
		logic [63:0] prod;
		prod = 64'(DELTA) * 64'(count);
		return prod[31:0];
	endfunction

endpackage

FILE: hdl/tea_half_round.sv
// One TEA half round followed by a pipeline register.
module tea_half_round #(
	parameter logic        HALF    = 1'b0,
	parameter logic [31:0] ENC_SUM = 32'd0,
	parameter logic [31:0] DEC_SUM = 32'd0
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            advance,
	input  logic            valid_in,
	input  tea_pkg::stage_t data_in,
	input  tea_pkg::key_t   keys,
	output logic            valid_out,
	output tea_pkg::stage_t data_out
);

	logic            upd_y;
	logic [31:0]     src;
	logic [31:0]     dst;
	logic [31:0]     sum;
	logic [31:0]     ka;
	logic [31:0]     kb;
	logic [31:0]     mix;
	logic [31:0]     res;
	tea_pkg::stage_t next;
	logic            valid_s1;
	tea_pkg::stage_t data_s1;

	// Pick which word is updated: the left word when op matches the half
	always_comb begin
		upd_y = (data_in.op == HALF);
		src   = upd_y ? data_in.z : data_in.y;
		dst   = upd_y ? data_in.y : data_in.z;
		ka    = upd_y ? keys.k0 : keys.k2;
		kb    = upd_y ? keys.k1 : keys.k3;
		sum   = (data_in.op == tea_pkg::OP_DECRYPT) ? DEC_SUM : ENC_SUM;
	end

	// Mix the source word and fold it into the target
	always_comb begin
		mix = ((src << 4) + ka) ^ (src + sum) ^ ((src >> 5) + kb);
		res = (data_in.op == tea_pkg::OP_DECRYPT) ? (dst - mix) : (dst + mix);
		next = data_in;
		if (upd_y) begin
			next.y = res;
		end else begin
			next.z = res;
		end
	end

	// Valid bit follows the beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= valid_in;
		end
	end

	// Hold the payload while stalled
	always_ff @(posedge clk) begin
		if (advance) begin
			data_s1 <= next;
		end
	end

	assign valid_out = valid_s1;
	assign data_out  = data_s1;

endmodule

FILE: hdl/tea_block_cipher_unit.sv
// Top level of the TEA block cipher unit: key registers and round pipeline.
//
//   channel  direction  handshake           beat
//   in       input      in_valid/in_stall   in_data   (operation, left, right word)
//   out      output     out_valid/out_stall out_data  (left, right word)
//   cfg      input      cfg_valid/cfg_ready cfg_index, cfg_data (key words 0..3)
//
// Each block passes 2*ROUNDS register stages, one half round per stage, and one
// block enters per cycle while the pipeline is not stalled.
// The last stage is the output register; out_stall freezes the whole pipeline
// whenever a result is waiting, and in_stall follows it. Reset clears all stage
// valid bits and loads the default key words. Configuration is always ready.
module tea_block_cipher_unit #(
	parameter int unsigned ROUNDS = tea_pkg::ROUNDS_DEFAULT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  tea_pkg::in_beat_t               in_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output tea_pkg::out_beat_t              out_data,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [tea_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [31:0]                     cfg_data
);

	localparam int unsigned STAGES = 2 * ROUNDS;

	tea_pkg::key_t   keys_q;
	logic            advance;
	logic            valid_chain [STAGES+1];
	tea_pkg::stage_t data_chain  [STAGES+1];

	// Key register writes
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keys_q.k0 <= tea_pkg::KEY_0_RESET;
			keys_q.k1 <= tea_pkg::KEY_1_RESET;
			keys_q.k2 <= tea_pkg::KEY_2_RESET;
			keys_q.k3 <= tea_pkg::KEY_3_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (tea_pkg::cfg_index_t'(cfg_index))
				tea_pkg::CFG_KEY_0: keys_q.k0 <= cfg_data;
				tea_pkg::CFG_KEY_1: keys_q.k1 <= cfg_data;
				tea_pkg::CFG_KEY_2: keys_q.k2 <= cfg_data;
				tea_pkg::CFG_KEY_3: keys_q.k3 <= cfg_data;
				default: ;
			endcase
		end
	end

	// Advance the pipeline unless a finished result is held
	assign advance  = !(out_valid && out_stall);
	assign in_stall = !advance;

	// Feed the first stage
	assign valid_chain[0]   = in_valid;
	assign data_chain[0].op = in_data.operation;
	assign data_chain[0].y  = in_data.left_word;
	assign data_chain[0].z  = in_data.right_word;

	// One half round per stage
	for (genvar j = 0; j < STAGES; j++) begin : g_stage
		localparam int unsigned RND = j / 2;

		tea_half_round #(
			.HALF    (1'(j % 2)),
			.ENC_SUM (tea_pkg::round_sum(RND + 1)),
			.DEC_SUM (tea_pkg::round_sum(ROUNDS - RND))
		) u_half (
			.clk       (clk),
			.arst_n    (arst_n),
			.advance   (advance),
			.valid_in  (valid_chain[j]),
			.data_in   (data_chain[j]),
			.keys      (keys_q),
			.valid_out (valid_chain[j+1]),
			.data_out  (data_chain[j+1])
		);
	end

	// Drive the result beat from the last stage
	assign out_valid               = valid_chain[STAGES];
	assign out_data.out_left_word  = data_chain[STAGES].y;
	assign out_data.out_right_word = data_chain[STAGES].z;

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the TEA block cipher unit: keyed phases, round trips, stalls.
module tb;

	localparam int unsigned ROUNDS       = tea_pkg::ROUNDS_DEFAULT;
	localparam int unsigned LATENCY      = 2 * ROUNDS;
	localparam int unsigned IDLE_PCT     = 34;
	localparam int unsigned HOLD_CYCLES  = 300;
	localparam int unsigned QUIET_LIMIT  = 4000;
	localparam int unsigned PHASE_BLOCKS = 150;
	localparam int unsigned RANDOM_SETS  = 6;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            in_valid = 1'b0;
	logic                            in_stall;
	tea_pkg::in_beat_t               in_data = '0;
	logic                            out_valid;
	logic                            out_stall = 1'b0;
	tea_pkg::out_beat_t              out_data;
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [tea_pkg::CFG_INDEX_W-1:0] cfg_index = tea_pkg::CFG_KEY_0;
	logic [31:0]                     cfg_data = '0;

	// Blocks waiting to enter, and predicted cipher outputs in arrival order
	tea_pkg::in_beat_t  pending_blocks[$];
	tea_pkg::out_beat_t predicted_out[$];
	tea_pkg::key_t      key_model;
	tea_pkg::out_beat_t want_beat;

	bit steady = 1'b0;
	bit hold_req = 1'b0;
	bit hold_done = 1'b0;
	int hold_cnt = 0;
	int errors = 0;
	int blocks_in = 0;
	int blocks_out = 0;
	int key_sets = 0;
	int quiet = 0;

	tea_block_cipher_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial forever #2 clk = ~clk;

	// One TEA half-round mixing term
	function automatic logic [31:0] feistel_mix(logic [31:0] v, logic [31:0] sum,
			logic [31:0] ka, logic [31:0] kb);
		return ((v << 4) + ka) ^ (v + sum) ^ ((v >> 5) + kb);
	endfunction

	// Full TEA transform of one block under the given key
	function automatic tea_pkg::out_beat_t tea_transform(tea_pkg::in_beat_t blk,
			tea_pkg::key_t k);
		logic [31:0]        y;
		logic [31:0]        z;
		logic [31:0]        sum;
		tea_pkg::out_beat_t res;
		y = blk.left_word;
		z = blk.right_word;
		if (blk.operation == tea_pkg::OP_ENCRYPT) begin
			sum = '0;
			for (int n = 0; n < ROUNDS; n++) begin
				sum = sum + tea_pkg::DELTA;
				y = y + feistel_mix(z, sum, k.k0, k.k1);
				z = z + feistel_mix(y, sum, k.k2, k.k3);
			end
		end else begin
			sum = 32'(tea_pkg::DELTA * ROUNDS);
			for (int n = 0; n < ROUNDS; n++) begin
				z = z - feistel_mix(y, sum, k.k2, k.k3);
				y = y - feistel_mix(z, sum, k.k0, k.k1);
				sum = sum - tea_pkg::DELTA;
			end
		end
		res.out_left_word = y;
		res.out_right_word = z;
		return res;
	endfunction

	function automatic tea_pkg::in_beat_t make_block(logic op, logic [31:0] y,
			logic [31:0] z);
		tea_pkg::in_beat_t b;
		b.operation = op;
		b.left_word = y;
		b.right_word = z;
		return b;
	endfunction

	// Mostly random words, with the corner values mixed in
	function automatic logic [31:0] pick_word();
		case ($urandom_range(15))
			0: return '0;
			1: return '1;
			2: return 32'h8000_0000;
			3: return 32'h0000_0001;
			default: return $urandom;
		endcase
	endfunction

	// Write one key word; cfg_valid is already high
	task automatic write_key(tea_pkg::cfg_index_t idx, logic [31:0] value);
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			tea_pkg::CFG_KEY_0: key_model.k0 = value;
			tea_pkg::CFG_KEY_1: key_model.k1 = value;
			tea_pkg::CFG_KEY_2: key_model.k2 = value;
			tea_pkg::CFG_KEY_3: key_model.k3 = value;
			default: ;
		endcase
	endtask

	task automatic load_keys(tea_pkg::key_t k);
		@(posedge clk);
		cfg_valid <= 1'b1;
		write_key(tea_pkg::CFG_KEY_0, k.k0);
		write_key(tea_pkg::CFG_KEY_1, k.k1);
		write_key(tea_pkg::CFG_KEY_2, k.k2);
		write_key(tea_pkg::CFG_KEY_3, k.k3);
		cfg_valid <= 1'b0;
		key_sets++;
	endtask

	// Wait until every queued block has entered and every result has come back
	task automatic drain();
		do @(negedge clk); while (pending_blocks.size() != 0 || predicted_out.size() != 0);
	endtask

	// Queue a block, then the inverse operation on its predicted output
	task automatic queue_round_trip(logic op, logic [31:0] y, logic [31:0] z);
		tea_pkg::in_beat_t  first;
		tea_pkg::out_beat_t mid;
		first = make_block(op, y, z);
		mid = tea_transform(first, key_model);
		pending_blocks.push_back(first);
		pending_blocks.push_back(make_block(~op, mid.out_left_word, mid.out_right_word));
	endtask

	// Sender: offer queued blocks, hold a stalled beat, predict on acceptance
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				predicted_out.push_back(tea_transform(in_data, key_model));
				void'(pending_blocks.pop_front());
				blocks_in++;
			end
			if (!(in_valid && in_stall)) begin
				if (pending_blocks.size() != 0 &&
						(steady || $urandom_range(99) >= IDLE_PCT)) begin
					in_valid <= 1'b1;
					in_data <= pending_blocks[0];
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: check each result beat against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (predicted_out.size() == 0) begin
					errors++;
					$display("%0t: result with none expected: %h %h", $time,
						out_data.out_left_word, out_data.out_right_word);
				end else begin
					want_beat = predicted_out.pop_front();
					blocks_out++;
					if (out_data.out_left_word !== want_beat.out_left_word) begin
						errors++;
						$display("%0t: out_left_word expected %h actual %h", $time,
							want_beat.out_left_word, out_data.out_left_word);
					end
					if (out_data.out_right_word !== want_beat.out_right_word) begin
						errors++;
						$display("%0t: out_right_word expected %h actual %h", $time,
							want_beat.out_right_word, out_data.out_right_word);
					end
				end
			end
			// Long hold-off once requested, otherwise random stalls
			if (hold_req && !hold_done) begin
				out_stall <= 1'b1;
				hold_cnt++;
				if (hold_cnt == HOLD_CYCLES)
					hold_done = 1'b1;
			end else begin
				out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
			end
		end
	end

	// Watchdog: end the run when no channel moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
					(cfg_valid && cfg_ready))
				quiet <= 0;
			else
				quiet <= quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("Traffic stopped after %0d of %0d blocks checked.", blocks_out,
					blocks_in);
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	initial begin
		tea_pkg::key_t k;
		int            added;
		key_model.k0 = tea_pkg::KEY_0_RESET;
		key_model.k1 = tea_pkg::KEY_1_RESET;
		key_model.k2 = tea_pkg::KEY_2_RESET;
		key_model.k3 = tea_pkg::KEY_3_RESET;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Reset keys: word extremes in both directions
		@(negedge clk);
		pending_blocks.push_back(make_block(tea_pkg::OP_ENCRYPT, '0, '0));
		pending_blocks.push_back(make_block(tea_pkg::OP_DECRYPT, '0, '0));
		pending_blocks.push_back(make_block(tea_pkg::OP_ENCRYPT, '1, '1));
		pending_blocks.push_back(make_block(tea_pkg::OP_DECRYPT, '1, '1));
		pending_blocks.push_back(make_block(tea_pkg::OP_ENCRYPT, '0, '1));
		pending_blocks.push_back(make_block(tea_pkg::OP_DECRYPT, '1, '0));
		pending_blocks.push_back(make_block(tea_pkg::OP_ENCRYPT, 32'h8000_0000,
			32'h0000_0001));
		pending_blocks.push_back(make_block(tea_pkg::OP_DECRYPT, 32'h0000_0001,
			32'h8000_0000));
		drain();

		// All-zero key, then all-ones key
		k = '0;
		load_keys(k);
		@(negedge clk);
		queue_round_trip(tea_pkg::OP_ENCRYPT, '0, '0);
		queue_round_trip(tea_pkg::OP_DECRYPT, '1, '1);
		drain();
		k = '1;
		load_keys(k);
		@(negedge clk);
		queue_round_trip(tea_pkg::OP_ENCRYPT, '1, '0);
		queue_round_trip(tea_pkg::OP_DECRYPT, '0, '1);
		drain();

		// Random phases: one with no idling, one with a long output hold-off
		for (int p = 0; p < RANDOM_SETS; p++) begin
			case (p)
				1: k = {32'h0, 32'hffff_ffff, 32'h0, 32'hffff_ffff};
				2: k = {32'hffff_ffff, 32'h0, 32'hffff_ffff, 32'h0};
				default: k = {$urandom, $urandom, $urandom, $urandom};
			endcase
			load_keys(k);
			@(negedge clk);
			steady = (p == 3);
			hold_req = (p == 4);
			added = 0;
			while (added < PHASE_BLOCKS) begin
				case ($urandom_range(9))
					0, 1, 2, 3: begin
						queue_round_trip(tea_pkg::OP_ENCRYPT, pick_word(), pick_word());
						added += 2;
					end
					4, 5: begin
						queue_round_trip(tea_pkg::OP_DECRYPT, pick_word(), pick_word());
						added += 2;
					end
					default: begin
						pending_blocks.push_back(make_block(1'($urandom), pick_word(),
							pick_word()));
						added++;
					end
				endcase
			end
			drain();
			steady = 1'b0;
		end

		// Let any stray result show up before the verdict
		repeat (LATENCY + 16) @(posedge clk);
		$display("Checked %0d of %0d blocks over %0d key loads plus reset keys,", blocks_out,
			blocks_in, key_sets);
		$display("both directions, round trips, random stalls and a %0d-cycle output hold.",
			hold_cnt);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
